// ===== rtl/chc_pkg.sv =====
`timescale 1ns / 1ps
package chc_pkg;

  localparam int TABLE_DEPTH    = 1024;
  localparam int SLOT_W         = $clog2(TABLE_DEPTH);
  localparam int SIZE_W         = 11;
  localparam int KEY_W          = 64;
  localparam int LEN_W          = 4;
  localparam int MAX_KEY_BYTES  = 8;
  localparam int CNT_W          = 16;
  localparam int HASH_W         = 32;
  localparam int EVICTION_LIMIT = 100;
  localparam int MOVE_W         = 7;
  localparam int BIT_CNT_W      = 6;

  localparam logic [HASH_W-1:0] DJB_SEED = 32'd5381;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_RD_A,
    S_CHK_A,
    S_RD_B,
    S_CHK_B,
    S_RD_OTH,
    S_CHK_OTH,
    S_FRD_A,
    S_FCHK_A,
    S_FRD_B,
    S_FCHK_B,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_OTH,
    SEL_CLR
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_MOVE,
    WR_BUMP,
    WR_CLEAR
  } wr_kind_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic      load;
    logic      hash_start;
    logic      hash_move;
    logic      hash_step;
    logic      mod_start;
    logic      mod_step;
    logic      latch_ab;
    logic      set_oth;
    logic      init_move;
    logic      swap;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      wr_en;
    wr_kind_t  wr_kind;
    logic      clr_step;
    logic      res_load;
    logic      res_rd;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic mod_done;
    logic empty;
    logic holds_new;
    logic holds_move;
    logic len_zero;
  } stat_t;

endpackage

// ===== rtl/chc_dp.sv =====
`timescale 1ns / 1ps
module chc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chc_pkg::cmd_t                 cmd,
  output chc_pkg::stat_t                stat,
  input  logic [chc_pkg::SIZE_W-1:0]    table_size,
  input  logic [chc_pkg::KEY_W-1:0]     in_key_bytes,
  input  logic [chc_pkg::LEN_W-1:0]     in_key_length,
  output logic [chc_pkg::CNT_W-1:0]     res_count
);

  chc_pkg::entry_t mem [chc_pkg::TABLE_DEPTH];
  chc_pkg::entry_t rd_r;

  logic [chc_pkg::KEY_W-1:0]  nk_r, mk_r;
  logic [chc_pkg::LEN_W-1:0]  nl_r, ml_r;
  logic [chc_pkg::CNT_W-1:0]  mc_r;
  logic [chc_pkg::SLOT_W-1:0] a_r, b_r, at_r, oth_r, clr_r;
  logic [chc_pkg::HASH_W-1:0] ha_r, hb_r, qa_r, qb_r;
  logic [chc_pkg::SIZE_W-1:0] ra_r, rb_r;
  logic [chc_pkg::LEN_W-1:0]  hidx_r;
  logic [chc_pkg::BIT_CNT_W-1:0] mcnt_r;
  logic [chc_pkg::CNT_W-1:0]  res_r;

  logic [chc_pkg::LEN_W-1:0]  len_clamp;
  logic [chc_pkg::KEY_W-1:0]  key_mask;
  logic [chc_pkg::KEY_W-1:0]  wk_key;
  logic [chc_pkg::LEN_W-1:0]  wk_len;
  logic [7:0]                 cur_byte;
  logic [chc_pkg::HASH_W-1:0] byte_ext;
  logic [chc_pkg::SIZE_W-1:0] sz;
  logic [chc_pkg::SIZE_W:0]   pa, pb;
  logic [chc_pkg::SIZE_W-1:0] ra_nxt, rb_nxt;
  logic [chc_pkg::SLOT_W-1:0] sa, sb, addr;
  chc_pkg::entry_t            wdata;

  always_comb begin
    len_clamp = (in_key_length > chc_pkg::LEN_W'(chc_pkg::MAX_KEY_BYTES)) ?
                chc_pkg::LEN_W'(chc_pkg::MAX_KEY_BYTES) : in_key_length;
    for (int i = 0; i < chc_pkg::MAX_KEY_BYTES; i++) begin
      key_mask[8*i +: 8] = (chc_pkg::LEN_W'(i) < len_clamp) ? 8'hFF : 8'h00;
    end
  end

  assign wk_key   = cmd.hash_move ? mk_r : nk_r;
  assign wk_len   = cmd.hash_move ? ml_r : nl_r;
  assign cur_byte = wk_key[8*hidx_r[2:0] +: 8];
  assign byte_ext = {{(chc_pkg::HASH_W-8){cur_byte[7]}}, cur_byte};

  always_comb begin
    if (table_size == '0) begin
      sz = chc_pkg::SIZE_W'(1);
    end else if (table_size > chc_pkg::SIZE_W'(chc_pkg::TABLE_DEPTH)) begin
      sz = chc_pkg::SIZE_W'(chc_pkg::TABLE_DEPTH);
    end else begin
      sz = table_size;
    end
    pa = {ra_r, qa_r[chc_pkg::HASH_W-1]};
    pb = {rb_r, qb_r[chc_pkg::HASH_W-1]};
    ra_nxt = (pa >= {1'b0, sz}) ? chc_pkg::SIZE_W'(pa - {1'b0, sz}) : chc_pkg::SIZE_W'(pa);
    rb_nxt = (pb >= {1'b0, sz}) ? chc_pkg::SIZE_W'(pb - {1'b0, sz}) : chc_pkg::SIZE_W'(pb);
  end

  assign sa = ra_r[chc_pkg::SLOT_W-1:0];
  assign sb = rb_r[chc_pkg::SLOT_W-1:0];

  always_comb begin
    unique case (cmd.addr_sel)
      chc_pkg::SEL_A:   addr = a_r;
      chc_pkg::SEL_B:   addr = b_r;
      chc_pkg::SEL_OTH: addr = oth_r;
      default:          addr = clr_r;
    endcase
    wdata = rd_r;
    unique case (cmd.wr_kind)
      chc_pkg::WR_NEW: begin
        wdata.key = nk_r;
        wdata.len = nl_r;
        wdata.cnt = chc_pkg::CNT_W'(1);
      end
      chc_pkg::WR_MOVE: begin
        wdata.key = mk_r;
        wdata.len = ml_r;
        wdata.cnt = mc_r;
      end
      chc_pkg::WR_BUMP: begin
        if (rd_r.cnt != '1) begin
          wdata.cnt = rd_r.cnt + chc_pkg::CNT_W'(1);
        end
      end
      default: begin
        wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + chc_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nk_r <= in_key_bytes & key_mask;
      nl_r <= len_clamp;
    end
    if (cmd.init_move) begin
      mk_r <= nk_r;
      ml_r <= nl_r;
      mc_r <= chc_pkg::CNT_W'(1);
      at_r <= a_r;
    end
    if (cmd.swap) begin
      mk_r <= rd_r.key;
      ml_r <= rd_r.len;
      mc_r <= rd_r.cnt;
      at_r <= oth_r;
    end
    if (cmd.hash_start) begin
      ha_r   <= chc_pkg::DJB_SEED;
      hb_r   <= '0;
      hidx_r <= '0;
    end else if (cmd.hash_step) begin
      ha_r   <= (ha_r << 5) + ha_r + byte_ext;
      hb_r   <= byte_ext + (hb_r << 6) + (hb_r << 16) - hb_r;
      hidx_r <= hidx_r + chc_pkg::LEN_W'(1);
    end
    if (cmd.mod_start) begin
      qa_r   <= ha_r;
      qb_r   <= hb_r;
      ra_r   <= '0;
      rb_r   <= '0;
      mcnt_r <= '0;
    end else if (cmd.mod_step) begin
      qa_r   <= qa_r << 1;
      qb_r   <= qb_r << 1;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
      mcnt_r <= mcnt_r + chc_pkg::BIT_CNT_W'(1);
    end
    if (cmd.latch_ab) begin
      a_r <= sa;
      b_r <= sb;
    end
    if (cmd.set_oth) begin
      oth_r <= (at_r == sa) ? sb : sa;
    end
    if (cmd.res_load) begin
      res_r <= cmd.res_rd ? rd_r.cnt : '0;
    end
  end

  assign res_count = res_r;

  always_comb begin
    stat.clr_done   = (clr_r == '1);
    stat.hash_done  = (hidx_r == wk_len);
    stat.mod_done   = (mcnt_r == chc_pkg::BIT_CNT_W'(chc_pkg::HASH_W));
    stat.empty      = (rd_r.len == '0);
    stat.holds_new  = (rd_r.len == nl_r) && (rd_r.key == nk_r);
    stat.holds_move = (rd_r.len == ml_r) && (rd_r.key == mk_r);
    stat.len_zero   = (in_key_length == '0);
  end

endmodule

// ===== rtl/chc_ctrl.sv =====
`timescale 1ns / 1ps
module chc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_kind,
  input  chc_pkg::stat_t stat,
  output chc_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid,
  output logic           out_status
);

  chc_pkg::state_t state_r, state_nxt;
  logic [chc_pkg::MOVE_W-1:0] moves_r, moves_nxt;
  logic kind_r, kind_nxt;
  logic hmove_r, hmove_nxt;
  logic full_r, full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chc_pkg::S_CLEAR;
      moves_r <= '0;
      kind_r  <= chc_pkg::KIND_INSERT;
      hmove_r <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      moves_r <= moves_nxt;
      kind_r  <= kind_nxt;
      hmove_r <= hmove_nxt;
      full_r  <= full_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    moves_nxt = moves_r;
    kind_nxt  = kind_r;
    hmove_nxt = hmove_r;
    full_nxt  = full_r;
    unique case (state_r)
      chc_pkg::S_CLEAR: begin
        if (stat.clr_done) state_nxt = chc_pkg::S_IDLE;
      end
      chc_pkg::S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          hmove_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = stat.len_zero ? chc_pkg::S_OUT : chc_pkg::S_HASH;
        end
      end
      chc_pkg::S_HASH: begin
        if (stat.hash_done) state_nxt = chc_pkg::S_MOD;
      end
      chc_pkg::S_MOD: begin
        if (stat.mod_done) begin
          if (hmove_r) begin
            state_nxt = chc_pkg::S_RD_OTH;
          end else begin
            state_nxt = (kind_r == chc_pkg::KIND_LOOKUP) ? chc_pkg::S_FRD_A : chc_pkg::S_RD_A;
          end
        end
      end
      chc_pkg::S_RD_A:  state_nxt = chc_pkg::S_CHK_A;
      chc_pkg::S_CHK_A: begin
        state_nxt = (stat.empty || stat.holds_new) ? chc_pkg::S_FRD_A : chc_pkg::S_RD_B;
      end
      chc_pkg::S_RD_B:  state_nxt = chc_pkg::S_CHK_B;
      chc_pkg::S_CHK_B: begin
        if (stat.empty || stat.holds_new) begin
          state_nxt = chc_pkg::S_FRD_A;
        end else begin
          moves_nxt = '0;
          hmove_nxt = 1'b1;
          state_nxt = chc_pkg::S_HASH;
        end
      end
      chc_pkg::S_RD_OTH:  state_nxt = chc_pkg::S_CHK_OTH;
      chc_pkg::S_CHK_OTH: begin
        if (stat.empty || stat.holds_move) begin
          state_nxt = chc_pkg::S_FRD_A;
        end else if (moves_r == chc_pkg::MOVE_W'(chc_pkg::EVICTION_LIMIT)) begin
          full_nxt  = 1'b1;
          state_nxt = chc_pkg::S_FRD_A;
        end else begin
          moves_nxt = moves_r + chc_pkg::MOVE_W'(1);
          state_nxt = chc_pkg::S_HASH;
        end
      end
      chc_pkg::S_FRD_A:  state_nxt = chc_pkg::S_FCHK_A;
      chc_pkg::S_FCHK_A: state_nxt = stat.holds_new ? chc_pkg::S_OUT : chc_pkg::S_FRD_B;
      chc_pkg::S_FRD_B:  state_nxt = chc_pkg::S_FCHK_B;
      chc_pkg::S_FCHK_B: state_nxt = chc_pkg::S_OUT;
      chc_pkg::S_OUT:    state_nxt = chc_pkg::S_IDLE;
      default:           state_nxt = chc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.hash_move = hmove_r;
    unique case (state_r)
      chc_pkg::S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_kind  = chc_pkg::WR_CLEAR;
        cmd.addr_sel = chc_pkg::SEL_CLR;
        cmd.clr_step = 1'b1;
      end
      chc_pkg::S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.hash_start = 1'b1;
          cmd.res_load   = stat.len_zero;
        end
      end
      chc_pkg::S_HASH: begin
        if (stat.hash_done) cmd.mod_start = 1'b1;
        else cmd.hash_step = 1'b1;
      end
      chc_pkg::S_MOD: begin
        if (stat.mod_done) begin
          cmd.latch_ab = !hmove_r;
          cmd.set_oth  = hmove_r;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      chc_pkg::S_RD_A: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = chc_pkg::SEL_A;
      end
      chc_pkg::S_CHK_A: begin
        cmd.addr_sel = chc_pkg::SEL_A;
        cmd.wr_en    = stat.empty || stat.holds_new;
        cmd.wr_kind  = stat.empty ? chc_pkg::WR_NEW : chc_pkg::WR_BUMP;
      end
      chc_pkg::S_RD_B: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = chc_pkg::SEL_B;
      end
      chc_pkg::S_CHK_B: begin
        cmd.addr_sel = chc_pkg::SEL_B;
        cmd.wr_en    = stat.empty || stat.holds_new;
        cmd.wr_kind  = stat.empty ? chc_pkg::WR_NEW : chc_pkg::WR_BUMP;
        if (!(stat.empty || stat.holds_new)) begin
          cmd.init_move  = 1'b1;
          cmd.hash_start = 1'b1;
        end
      end
      chc_pkg::S_RD_OTH: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = chc_pkg::SEL_OTH;
      end
      chc_pkg::S_CHK_OTH: begin
        cmd.addr_sel = chc_pkg::SEL_OTH;
        cmd.wr_en    = 1'b1;
        cmd.wr_kind  = stat.holds_move ? chc_pkg::WR_BUMP : chc_pkg::WR_MOVE;
        if (!(stat.empty || stat.holds_move)) begin
          cmd.swap       = 1'b1;
          cmd.hash_start = 1'b1;
        end
      end
      chc_pkg::S_FRD_A: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = chc_pkg::SEL_A;
      end
      chc_pkg::S_FCHK_A: begin
        cmd.res_load = stat.holds_new;
        cmd.res_rd   = 1'b1;
      end
      chc_pkg::S_FRD_B: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = chc_pkg::SEL_B;
      end
      chc_pkg::S_FCHK_B: begin
        cmd.res_load = 1'b1;
        cmd.res_rd   = stat.holds_new;
      end
      default: begin
        cmd.hash_move = hmove_r;
      end
    endcase
  end

  assign busy       = (state_r != chc_pkg::S_IDLE);
  assign out_valid  = (state_r == chc_pkg::S_OUT);
  assign out_status = full_r;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_move_bound: assert property (@(posedge clk) disable iff (!rst_n)
    moves_r <= chc_pkg::MOVE_W'(chc_pkg::EVICTION_LIMIT)) else $error("move count overrun");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (kind_r == chc_pkg::KIND_INSERT))
    else $error("lookup reported full");
`endif

endmodule

// ===== rtl/cuckoo_hash_counter.sv =====
`timescale 1ns / 1ps
// Counting cuckoo hash table for keys of one to eight bytes.
// Input: a beat is taken when start is high and busy is low; in_kind selects
// insert (0) or lookup (1), in_key_bytes and in_key_length give the key.
// Output: one result per beat, shown for exactly one cycle with out_valid high,
// carrying out_count and out_status. The receiver cannot stall the block.
// Configuration: table_size at byte address 0 of the cfg_ APB port; the user
// must write it only while busy is low; the block does not enforce this.
// Operation: both slot hashes are computed together over the key bytes, then
// both remainders come from bit-serial division, the two running in parallel.
// A lookup reads the key's first slot and, if the key is not there, its
// second; a zero-length key answers with no table access. An insert writes
// the first slot that is empty or holds the key; if both hold other keys,
// cuckoo moves follow, up to 101 of them. Busy drops in the cycle after the
// strobe, so one beat is in flight at a time, set by the single table port.
// Reset: after rst_n is released, a clearing pass walks all 1024 slots, one
// per cycle, and busy stays high for that time.
module cuckoo_hash_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [chc_pkg::KEY_W-1:0]     in_key_bytes,
  input  logic [chc_pkg::LEN_W-1:0]     in_key_length,
  output logic                          out_valid,
  output logic [chc_pkg::CNT_W-1:0]     out_count,
  output logic                          out_status,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [1:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [chc_pkg::SIZE_W-1:0] table_size_r;
  chc_pkg::cmd_t  cmd;
  chc_pkg::stat_t stat;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= chc_pkg::SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == chc_pkg::ADDR_TABLE_SIZE) begin
      table_size_r <= cfg_pwdata[chc_pkg::SIZE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == chc_pkg::ADDR_TABLE_SIZE) ?
                      {{(32-chc_pkg::SIZE_W){1'b0}}, table_size_r} : '0;

  chc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_kind    (in_kind),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  chc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .table_size    (table_size_r),
    .in_key_bytes  (in_key_bytes),
    .in_key_length (in_key_length),
    .res_count     (out_count)
  );

endmodule
